// File: rtl/cmdpk_pkg.sv
package cmdpk_pkg;

  localparam int NUM_LANES  = 5;
  localparam int QUO_W      = 16;
  localparam int DIV_W      = 32;
  localparam int NUM_W      = DIV_W + QUO_W;
  localparam int POS_BITS   = 16;
  localparam int OTHER_BITS = 12;
  localparam int ID_W       = 11;
  localparam int CFG_IDX_W  = 4;
  localparam int NUM_REGS   = 8;
  localparam int REG_IDX_W  = $clog2(NUM_REGS);

  localparam logic signed [31:0] STIFF_MIN_DEF = 32'sd0;
  localparam logic signed [31:0] DAMP_MIN_DEF  = 32'sd0;

  localparam logic signed [31:0] POS_MIN_RST    = -32'sd819200;
  localparam logic signed [31:0] POS_MAX_RST    = 32'sd819200;
  localparam logic signed [31:0] VEL_MIN_RST    = -32'sd3276800;
  localparam logic signed [31:0] VEL_MAX_RST    = 32'sd3276800;
  localparam logic signed [31:0] STIFF_MAX_RST  = 32'sd32768000;
  localparam logic signed [31:0] DAMP_MAX_RST   = 32'sd327680;
  localparam logic signed [31:0] TORQUE_MIN_RST = -32'sd1179648;
  localparam logic signed [31:0] TORQUE_MAX_RST = 32'sd1179648;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POS_MIN    = 4'd0,
    REG_POS_MAX    = 4'd1,
    REG_VEL_MIN    = 4'd2,
    REG_VEL_MAX    = 4'd3,
    REG_STIFF_MAX  = 4'd4,
    REG_DAMP_MAX   = 4'd5,
    REG_TORQUE_MIN = 4'd6,
    REG_TORQUE_MAX = 4'd7
  } cfg_reg_t;

  // Lane order: 0 position, 1 velocity, 2 stiffness, 3 damping, 4 torque.
  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [DIV_W-1:0] dvs;
    logic [QUO_W-1:0] quo;
  } lane_t;

  typedef struct packed {
    logic                 vld;
    logic [ID_W-1:0]      id;
    logic [NUM_LANES-1:0] bad;
  } ctrl_t;

  typedef struct packed {
    ctrl_t                   ctrl;
    lane_t [NUM_LANES-1:0]   lane;
  } stage_t;

endpackage

// File: rtl/cmdpk_quant_front.sv
module cmdpk_quant_front
  import cmdpk_pkg::*;
#(
  parameter int BITS = OTHER_BITS
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] x,
  input  logic signed [31:0] lo,
  input  logic signed [31:0] hi,
  output lane_t              lane,
  output logic               bad
);

  logic signed [31:0] xc;
  logic signed [32:0] off_w;
  logic signed [32:0] span_w;
  logic               bad_w;
  logic [DIV_W-1:0]   off_r, off_nxt;
  logic [DIV_W-1:0]   span_r, span_nxt;
  logic               bad1_r;
  lane_t              lane_r, lane_nxt;
  logic               bad2_r;

  // First stage: clamp and take offset and span.
  always_comb begin
    bad_w = (hi <= lo);
    if (x < lo) begin
      xc = lo;
    end else if (x > hi) begin
      xc = hi;
    end else begin
      xc = x;
    end
    off_w  = 33'(xc) - 33'(lo);
    span_w = 33'(hi) - 33'(lo);
    if (bad_w) begin
      off_nxt  = '0;
      span_nxt = DIV_W'(1);
    end else begin
      off_nxt  = off_w[DIV_W-1:0];
      span_nxt = span_w[DIV_W-1:0];
    end
  end

  // Second stage: numerator off * (2^BITS - 1) as a shift and subtract.
  always_comb begin
    lane_nxt.rem = ({{QUO_W{1'b0}}, off_r} << BITS) - {{QUO_W{1'b0}}, off_r};
    lane_nxt.dvs = span_r;
    lane_nxt.quo = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      off_r  <= off_nxt;
      span_r <= span_nxt;
      bad1_r <= bad_w;
      lane_r <= lane_nxt;
      bad2_r <= bad1_r;
    end
  end

  assign lane = lane_r;
  assign bad  = bad2_r;

endmodule

// File: rtl/cmdpk_div_step.sv
module cmdpk_div_step
  import cmdpk_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   en,
  input  stage_t d,
  output stage_t q
);

  stage_t           q_r, q_nxt;
  logic [NUM_W-1:0] sub;

  // One restoring-division step on every lane for quotient bit STEP.
  always_comb begin
    q_nxt = d;
    sub   = '0;
    for (int l = 0; l < NUM_LANES; l++) begin
      sub = {{QUO_W{1'b0}}, d.lane[l].dvs} << STEP;
      if (d.lane[l].rem >= sub) begin
        q_nxt.lane[l].rem       = d.lane[l].rem - sub;
        q_nxt.lane[l].quo[STEP] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.ctrl.vld <= 1'b0;
    end else if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

// File: rtl/motor_command_frame_pack.sv
// Motor command frame packer. Each input transaction carries a CAN id and five
// signed Q16.16 targets; each target is clamped to its configured range and
// quantized as floor((x - min) * (2^bits - 1) / (max - min)), 16 bits for
// position and 12 bits for the others, and packed into a 64-bit payload with
// position in the top bits. A range whose max is not above min gives code 0
// and sets out_tuser (range_error). The pipeline takes one transaction per
// cycle unless stalled. A clamp stage and a numerator stage come first, then a
// 16-stage restoring divider that yields one quotient bit per stage. The whole
// pipeline stalls together when the output holds a result that is not taken.
// Configuration writes are always accepted and must only happen while idle.
module motor_command_frame_pack
  import cmdpk_pkg::*;
#(
  parameter logic signed [31:0] STIFF_MIN_Q = STIFF_MIN_DEF,
  parameter logic signed [31:0] DAMP_MIN_Q  = DAMP_MIN_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // frame_id, pos_target, vel_target, stiff_gain, damp_gain, torque_ff, pad
  input  logic [175:0]         in_tdata,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // out_id, payload, pad
  output logic [79:0]          out_tdata,
  // range_error
  output logic                 out_tuser,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int NSTEP = QUO_W;

  logic signed [31:0] cfg_r [NUM_REGS];
  logic               adv;
  ctrl_t              c1_r, c2_r;
  stage_t             st [NSTEP+1];
  lane_t [NUM_LANES-1:0] fl;
  logic  [NUM_LANES-1:0] fbad;
  logic signed [31:0] xin [NUM_LANES];
  logic signed [31:0] lov [NUM_LANES];
  logic signed [31:0] hiv [NUM_LANES];

  assign cfg_ready = 1'b1;

  // Register file; writes beyond the last register are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r[REG_IDX_W'(REG_POS_MIN)]    <= POS_MIN_RST;
      cfg_r[REG_IDX_W'(REG_POS_MAX)]    <= POS_MAX_RST;
      cfg_r[REG_IDX_W'(REG_VEL_MIN)]    <= VEL_MIN_RST;
      cfg_r[REG_IDX_W'(REG_VEL_MAX)]    <= VEL_MAX_RST;
      cfg_r[REG_IDX_W'(REG_STIFF_MAX)]  <= STIFF_MAX_RST;
      cfg_r[REG_IDX_W'(REG_DAMP_MAX)]   <= DAMP_MAX_RST;
      cfg_r[REG_IDX_W'(REG_TORQUE_MIN)] <= TORQUE_MIN_RST;
      cfg_r[REG_IDX_W'(REG_TORQUE_MAX)] <= TORQUE_MAX_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_POS_MIN:    cfg_r[REG_IDX_W'(REG_POS_MIN)]    <= cfg_data;
        REG_POS_MAX:    cfg_r[REG_IDX_W'(REG_POS_MAX)]    <= cfg_data;
        REG_VEL_MIN:    cfg_r[REG_IDX_W'(REG_VEL_MIN)]    <= cfg_data;
        REG_VEL_MAX:    cfg_r[REG_IDX_W'(REG_VEL_MAX)]    <= cfg_data;
        REG_STIFF_MAX:  cfg_r[REG_IDX_W'(REG_STIFF_MAX)]  <= cfg_data;
        REG_DAMP_MAX:   cfg_r[REG_IDX_W'(REG_DAMP_MAX)]   <= cfg_data;
        REG_TORQUE_MIN: cfg_r[REG_IDX_W'(REG_TORQUE_MIN)] <= cfg_data;
        REG_TORQUE_MAX: cfg_r[REG_IDX_W'(REG_TORQUE_MAX)] <= cfg_data;
        default: ;
      endcase
    end
  end

  // The pipeline moves as a whole whenever the output stage is free or drains.
  assign adv       = !st[NSTEP].ctrl.vld || out_tready;
  assign in_tready = adv;

  assign xin[0] = in_tdata[42:11];
  assign xin[1] = in_tdata[74:43];
  assign xin[2] = in_tdata[106:75];
  assign xin[3] = in_tdata[138:107];
  assign xin[4] = in_tdata[170:139];
  assign lov[0] = cfg_r[REG_IDX_W'(REG_POS_MIN)];
  assign hiv[0] = cfg_r[REG_IDX_W'(REG_POS_MAX)];
  assign lov[1] = cfg_r[REG_IDX_W'(REG_VEL_MIN)];
  assign hiv[1] = cfg_r[REG_IDX_W'(REG_VEL_MAX)];
  assign lov[2] = STIFF_MIN_Q;
  assign hiv[2] = cfg_r[REG_IDX_W'(REG_STIFF_MAX)];
  assign lov[3] = DAMP_MIN_Q;
  assign hiv[3] = cfg_r[REG_IDX_W'(REG_DAMP_MAX)];
  assign lov[4] = cfg_r[REG_IDX_W'(REG_TORQUE_MIN)];
  assign hiv[4] = cfg_r[REG_IDX_W'(REG_TORQUE_MAX)];

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_front
    cmdpk_quant_front #(
      .BITS ((g == 0) ? POS_BITS : OTHER_BITS)
    ) u_front (
      .clk  (clk),
      .en   (adv),
      .x    (xin[g]),
      .lo   (lov[g]),
      .hi   (hiv[g]),
      .lane (fl[g]),
      .bad  (fbad[g])
    );
  end

  // Control rides alongside the two front stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r.vld <= 1'b0;
      c2_r.vld <= 1'b0;
    end else if (adv) begin
      c1_r.vld <= in_tvalid;
      c1_r.id  <= in_tdata[ID_W-1:0];
      c1_r.bad <= '0;
      c2_r     <= c1_r;
    end
  end

  always_comb begin
    st[0].ctrl.vld = c2_r.vld;
    st[0].ctrl.id  = c2_r.id;
    st[0].ctrl.bad = fbad;
    st[0].lane     = fl;
  end

  // Quotient bits from the most significant down, one per stage.
  for (genvar s = 0; s < NSTEP; s++) begin : g_div
    cmdpk_div_step #(
      .STEP (NSTEP - 1 - s)
    ) u_step (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (adv),
      .d     (st[s]),
      .q     (st[s+1])
    );
  end

  assign out_tvalid = st[NSTEP].ctrl.vld;
  assign out_tuser  = |st[NSTEP].ctrl.bad;
  assign out_tdata  = {5'd0,
                       st[NSTEP].lane[0].quo[POS_BITS-1:0],
                       st[NSTEP].lane[1].quo[OTHER_BITS-1:0],
                       st[NSTEP].lane[2].quo[OTHER_BITS-1:0],
                       st[NSTEP].lane[3].quo[OTHER_BITS-1:0],
                       st[NSTEP].lane[4].quo[OTHER_BITS-1:0],
                       st[NSTEP].ctrl.id};

`ifndef NO_ASSERTIONS
  // An accepted command shows up in the first front stage.
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> c1_r.vld)
    else $error("accepted command not captured");

  // A stalled pipeline keeps the valid bits of its last and middle divider stages.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> ($stable(st[NSTEP].ctrl.vld) && $stable(st[NSTEP/2].ctrl.vld)))
    else $error("stalled pipeline changed");

  // The 12-bit velocity and torque codes never reach above their field.
  a_narrow: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (st[NSTEP].lane[4].quo[QUO_W-1:OTHER_BITS] == '0 &&
                    st[NSTEP].lane[1].quo[QUO_W-1:OTHER_BITS] == '0))
    else $error("12-bit code overflow");

  // An empty torque range yields code zero.
  a_badzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && st[NSTEP].ctrl.bad[4]) |-> (st[NSTEP].lane[4].quo == '0))
    else $error("empty range gave nonzero code");
`endif

endmodule
